### rtl/lfpd_pkg.sv
// ----------------------------------------------------------------------------
// lfpd_pkg: shared types and constants of the PD steering block
// Widths, register codes, reset values and the stage control struct.
// ----------------------------------------------------------------------------
package lfpd_pkg;

	// Row geometry and lane split
	localparam int RowCount    = 12;
	localparam int LaneCount   = 4;
	localparam int RowsPerLane = RowCount / LaneCount;
	localparam int RowW        = 8;
	localparam int LaneSumW    = 10;
	localparam int SumW        = 12;

	// Divide-by-3 reciprocal, exact for values below 2048
	localparam int QuarterW    = SumW - 2;
	localparam int Recip3      = 683;
	localparam int Recip3Shift = 11;
	localparam int RecipProdW  = 2 * QuarterW;

	// Datapath widths
	localparam int ErrW     = 9;
	localparam int ChgW     = 10;
	localparam int GainW    = 12;
	localparam int ProdPW   = GainW + 1 + ErrW;
	localparam int ProdDW   = GainW + 1 + ChgW;
	localparam int DriveW   = ProdDW + 1;
	localparam int ShamtW   = 4;
	localparam int QBits    = 8;
	localparam int LimitW   = 10;
	localparam int OffW     = 11;
	localparam int CenterW  = 12;
	localparam int DutyW    = 13;
	localparam int DutySumW = 15;
	localparam int DutyMax  = 8191;

	// Configuration port
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 12;

	typedef enum logic [CfgIdxW-1:0] {
		REG_SETPOINT     = 3'd0,
		REG_KP_Q8        = 3'd1,
		REG_KD_Q8        = 3'd2,
		REG_BAND         = 3'd3,
		REG_REDUCE_SHIFT = 3'd4,
		REG_OFFSET_LIMIT = 3'd5,
		REG_CENTER_DUTY  = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0]         setpoint;
		logic [GainW-1:0]   kp_q8;
		logic [GainW-1:0]   kd_q8;
		logic [7:0]         band;
		logic [2:0]         reduce_shift;
		logic [LimitW-1:0]  offset_limit;
		logic [CenterW-1:0] center_duty;
	} cfg_t;

	localparam cfg_t CfgReset = '{
		setpoint:     8'd92,
		kp_q8:        12'd666,
		kd_q8:        12'd31,
		band:         8'd30,
		reduce_shift: 3'd2,
		offset_limit: 10'd70,
		center_duty:  12'd790
	};

	// Load enables of the four pipeline stages
	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
		logic en4;
	} pipe_en_t;

endpackage

### rtl/lfpd_rows_if.sv
// ----------------------------------------------------------------------------
// lfpd_rows_if: row-center input channel
// Valid/ready channel carrying twelve track-center columns.
// ----------------------------------------------------------------------------
interface lfpd_rows_if;
	logic       valid;
	logic       ready;
	logic [7:0] row_center_0;
	logic [7:0] row_center_1;
	logic [7:0] row_center_2;
	logic [7:0] row_center_3;
	logic [7:0] row_center_4;
	logic [7:0] row_center_5;
	logic [7:0] row_center_6;
	logic [7:0] row_center_7;
	logic [7:0] row_center_8;
	logic [7:0] row_center_9;
	logic [7:0] row_center_10;
	logic [7:0] row_center_11;

	modport source (
		output valid, row_center_0, row_center_1, row_center_2, row_center_3,
		row_center_4, row_center_5, row_center_6, row_center_7, row_center_8,
		row_center_9, row_center_10, row_center_11,
		input  ready
	);
	modport sink (
		input  valid, row_center_0, row_center_1, row_center_2, row_center_3,
		row_center_4, row_center_5, row_center_6, row_center_7, row_center_8,
		row_center_9, row_center_10, row_center_11,
		output ready
	);
endinterface

### rtl/lfpd_steer_if.sv
// ----------------------------------------------------------------------------
// lfpd_steer_if: steering result channel
// Valid/ready channel carrying servo duty, offset and gain flag.
// ----------------------------------------------------------------------------
interface lfpd_steer_if;
	logic        valid;
	logic        ready;
	logic [12:0] servo_duty;
	logic signed [10:0] steer_offset;
	logic        full_gain;

	modport source (output valid, servo_duty, steer_offset, full_gain, input ready);
	modport sink   (input valid, servo_duty, steer_offset, full_gain, output ready);
endinterface

### rtl/lfpd_cfg_if.sv
// ----------------------------------------------------------------------------
// lfpd_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface lfpd_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [11:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### rtl/lfpd_lane.sv
// ----------------------------------------------------------------------------
// lfpd_lane: partial row sum
// Adds the rows assigned to one lane and registers the partial sum.
// ----------------------------------------------------------------------------
module lfpd_lane (
	input  logic clk,
	input  logic en,
	input  logic [lfpd_pkg::RowsPerLane-1:0][lfpd_pkg::RowW-1:0] rows,
	output logic [lfpd_pkg::LaneSumW-1:0] lane_sum_s1
);

	logic [lfpd_pkg::LaneSumW-1:0] sum_c;

	// Sum this lane's rows
	always_comb begin
		sum_c = '0;
		for (int i = 0; i < lfpd_pkg::RowsPerLane; i++) begin
			sum_c = sum_c + lfpd_pkg::LaneSumW'(rows[i]);
		end
	end

	// Hold the partial sum for the merge stage
	always_ff @(posedge clk) begin
		if (en) begin
			lane_sum_s1 <= sum_c;
		end
	end

endmodule

### rtl/lfpd_merge.sv
// ----------------------------------------------------------------------------
// lfpd_merge: lane merge and error stage
// Combines lane sums, divides by twelve, forms error, change and band flag.
// ----------------------------------------------------------------------------
module lfpd_merge (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [lfpd_pkg::LaneCount-1:0][lfpd_pkg::LaneSumW-1:0] lane_sum_s1,
	input  lfpd_pkg::cfg_t cfg,
	output logic signed [lfpd_pkg::ErrW-1:0] err_s2,
	output logic signed [lfpd_pkg::ChgW-1:0] chg_s2,
	output logic full_s2
);

	logic [lfpd_pkg::SumW-1:0]       total_c;
	logic [lfpd_pkg::QuarterW-1:0]   quarter_c;
	logic [lfpd_pkg::RecipProdW-1:0] recip_prod_c;
	logic [7:0]                      avg_c;
	logic signed [lfpd_pkg::ErrW-1:0] err_c;
	logic signed [lfpd_pkg::ChgW-1:0] chg_c;
	logic signed [lfpd_pkg::ChgW-1:0] err_wide_c;
	logic signed [lfpd_pkg::ChgW-1:0] band_c;
	logic full_c;
	logic signed [lfpd_pkg::ErrW-1:0] prev_error_q;

	// Merge lanes, then divide by 12 as a shift by 2 and a reciprocal of 3
	always_comb begin
		total_c = '0;
		for (int i = 0; i < lfpd_pkg::LaneCount; i++) begin
			total_c = total_c + lfpd_pkg::SumW'(lane_sum_s1[i]);
		end
		quarter_c    = total_c[lfpd_pkg::SumW-1:2];
		recip_prod_c = lfpd_pkg::RecipProdW'(quarter_c)
			* lfpd_pkg::RecipProdW'(lfpd_pkg::Recip3);
		avg_c        = recip_prod_c[lfpd_pkg::Recip3Shift +: 8];
	end

	// Error, change from the previous error, and band test
	always_comb begin
		err_c      = $signed({1'b0, avg_c}) - $signed({1'b0, cfg.setpoint});
		err_wide_c = lfpd_pkg::ChgW'(err_c);
		chg_c      = err_wide_c - lfpd_pkg::ChgW'(prev_error_q);
		band_c     = $signed({2'b00, cfg.band});
		full_c     = (err_wide_c > band_c) || (err_wide_c < -band_c);
	end

	// Keep the error of the last transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q <= '0;
		end else if (en) begin
			prev_error_q <= err_c;
		end
	end

	// Stage register
	always_ff @(posedge clk) begin
		if (en) begin
			err_s2  <= err_c;
			chg_s2  <= chg_c;
			full_s2 <= full_c;
		end
	end

endmodule

### rtl/lfpd_drive.sv
// ----------------------------------------------------------------------------
// lfpd_drive: PD drive, scaling, clamp and duty
// Multiplies by the gains, shifts toward zero, clamps and saturates the duty.
// ----------------------------------------------------------------------------
module lfpd_drive (
	input  logic clk,
	input  lfpd_pkg::pipe_en_t pipe,
	input  lfpd_pkg::cfg_t cfg,
	input  logic signed [lfpd_pkg::ErrW-1:0] err_s2,
	input  logic signed [lfpd_pkg::ChgW-1:0] chg_s2,
	input  logic full_s2,
	output logic [lfpd_pkg::DutyW-1:0] servo_duty_s4,
	output logic signed [lfpd_pkg::OffW-1:0] steer_offset_s4,
	output logic full_gain_s4
);

	logic signed [lfpd_pkg::GainW:0]    kp_c;
	logic signed [lfpd_pkg::GainW:0]    kd_c;
	logic signed [lfpd_pkg::ProdPW-1:0] prod_p_c;
	logic signed [lfpd_pkg::ProdDW-1:0] prod_d_c;
	logic signed [lfpd_pkg::ProdPW-1:0] prod_p_s3;
	logic signed [lfpd_pkg::ProdDW-1:0] prod_d_s3;
	logic full_s3;

	logic signed [lfpd_pkg::DriveW-1:0] drive_c;
	logic                               neg_c;
	logic [lfpd_pkg::DriveW-1:0]        mag_c;
	logic [lfpd_pkg::ShamtW-1:0]        shamt_c;
	logic [lfpd_pkg::DriveW-1:0]        shifted_c;
	logic [lfpd_pkg::LimitW-1:0]        off_mag_c;
	logic [lfpd_pkg::OffW-1:0]          off_c;
	logic [lfpd_pkg::DutySumW-1:0]      duty_sum_c;
	logic [lfpd_pkg::DutyW-1:0]         duty_c;

	// Gain products
	always_comb begin
		kp_c     = $signed({1'b0, cfg.kp_q8});
		kd_c     = $signed({1'b0, cfg.kd_q8});
		prod_p_c = kp_c * err_s2;
		prod_d_c = kd_c * chg_s2;
	end

	always_ff @(posedge clk) begin
		if (pipe.en3) begin
			prod_p_s3 <= prod_p_c;
			prod_d_s3 <= prod_d_c;
			full_s3   <= full_s2;
		end
	end

	// Drive, shift toward zero on the magnitude, clamp
	always_comb begin
		drive_c   = lfpd_pkg::DriveW'(prod_p_s3) - lfpd_pkg::DriveW'(prod_d_s3);
		neg_c     = drive_c[lfpd_pkg::DriveW-1];
		mag_c     = neg_c ? lfpd_pkg::DriveW'(-drive_c) : lfpd_pkg::DriveW'(drive_c);
		shamt_c   = lfpd_pkg::ShamtW'(lfpd_pkg::QBits)
			+ (full_s3 ? '0 : lfpd_pkg::ShamtW'(cfg.reduce_shift));
		shifted_c = mag_c >> shamt_c;
		if (shifted_c > lfpd_pkg::DriveW'(cfg.offset_limit)) begin
			off_mag_c = cfg.offset_limit;
		end else begin
			off_mag_c = shifted_c[lfpd_pkg::LimitW-1:0];
		end
		off_c = neg_c ? -{1'b0, off_mag_c} : {1'b0, off_mag_c};
	end

	// Center plus offset, saturated to the duty range
	always_comb begin
		duty_sum_c = lfpd_pkg::DutySumW'(cfg.center_duty)
			+ {{(lfpd_pkg::DutySumW-lfpd_pkg::OffW){off_c[lfpd_pkg::OffW-1]}}, off_c};
		if (duty_sum_c[lfpd_pkg::DutySumW-1]) begin
			duty_c = '0;
		end else if (duty_sum_c > lfpd_pkg::DutySumW'(lfpd_pkg::DutyMax)) begin
			duty_c = lfpd_pkg::DutyW'(lfpd_pkg::DutyMax);
		end else begin
			duty_c = duty_sum_c[lfpd_pkg::DutyW-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (pipe.en4) begin
			servo_duty_s4   <= duty_c;
			steer_offset_s4 <= $signed(off_c);
			full_gain_s4    <= full_s3;
		end
	end

endmodule

### rtl/line_follow_pd_steering.sv
// ----------------------------------------------------------------------------
// line_follow_pd_steering: PD steering controller with offset clamp
//
//   channel | modport | carries
//   --------+---------+------------------------------------------------
//   rows    | sink    | row_center_0 .. row_center_11, 8 bit each
//   steer   | source  | servo_duty 13b, steer_offset 11b signed, full_gain
//   cfg     | sink    | index 3b, data 12b register write, always ready
//
// One transaction per cycle while steer is ready; each result passes the
// stages in order (lane sums, merge/error, gain multiply, shift/clamp/duty).
// Every stage has its own valid bit, so a stalled result only blocks input
// once all four stages are full. Reset clears valid bits, the previous error
// and restores register defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module line_follow_pd_steering (
	input  logic clk,
	input  logic arst_n,
	lfpd_rows_if.sink   rows,
	lfpd_steer_if.source steer,
	lfpd_cfg_if.sink    cfg
);

	lfpd_pkg::cfg_t   cfg_q;
	lfpd_pkg::pipe_en_t pipe;
	logic v1_q, v2_q, v3_q, v4_q;

	logic [lfpd_pkg::RowCount-1:0][lfpd_pkg::RowW-1:0] row_vec;
	logic [lfpd_pkg::LaneCount-1:0][lfpd_pkg::LaneSumW-1:0] lane_sum_s1;

	logic signed [lfpd_pkg::ErrW-1:0] err_s2;
	logic signed [lfpd_pkg::ChgW-1:0] chg_s2;
	logic full_s2;

	// Register writes: ignore indexes past the list
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= lfpd_pkg::CfgReset;
		end else if (cfg.valid) begin
			case (lfpd_pkg::cfg_idx_t'(cfg.index))
				lfpd_pkg::REG_SETPOINT:     cfg_q.setpoint     <= cfg.data[7:0];
				lfpd_pkg::REG_KP_Q8:        cfg_q.kp_q8        <= cfg.data;
				lfpd_pkg::REG_KD_Q8:        cfg_q.kd_q8        <= cfg.data;
				lfpd_pkg::REG_BAND:         cfg_q.band         <= cfg.data[7:0];
				lfpd_pkg::REG_REDUCE_SHIFT: cfg_q.reduce_shift <= cfg.data[2:0];
				lfpd_pkg::REG_OFFSET_LIMIT: cfg_q.offset_limit <= cfg.data[9:0];
				lfpd_pkg::REG_CENTER_DUTY:  cfg_q.center_duty  <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Stage enables: advance a stage when the next one is empty or moving
	always_comb begin
		pipe.en4   = v3_q && (!v4_q || steer.ready);
		pipe.en3   = v2_q && (!v3_q || pipe.en4);
		pipe.en2   = v1_q && (!v2_q || pipe.en3);
		rows.ready = !v1_q || pipe.en2;
		pipe.en1   = rows.valid && rows.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (pipe.en1) v1_q <= 1'b1; else if (pipe.en2) v1_q <= 1'b0;
			if (pipe.en2) v2_q <= 1'b1; else if (pipe.en3) v2_q <= 1'b0;
			if (pipe.en3) v3_q <= 1'b1; else if (pipe.en4) v3_q <= 1'b0;
			if (pipe.en4) v4_q <= 1'b1; else if (steer.ready) v4_q <= 1'b0;
		end
	end

	// Gather rows for the lanes
	always_comb begin
		row_vec[0]  = rows.row_center_0;
		row_vec[1]  = rows.row_center_1;
		row_vec[2]  = rows.row_center_2;
		row_vec[3]  = rows.row_center_3;
		row_vec[4]  = rows.row_center_4;
		row_vec[5]  = rows.row_center_5;
		row_vec[6]  = rows.row_center_6;
		row_vec[7]  = rows.row_center_7;
		row_vec[8]  = rows.row_center_8;
		row_vec[9]  = rows.row_center_9;
		row_vec[10] = rows.row_center_10;
		row_vec[11] = rows.row_center_11;
	end

	// Lanes: each sums a contiguous group of rows
	for (genvar g = 0; g < lfpd_pkg::LaneCount; g++) begin : g_lane
		lfpd_lane u_lane (
			.clk         (clk),
			.en          (pipe.en1),
			.rows        (row_vec[g*lfpd_pkg::RowsPerLane +: lfpd_pkg::RowsPerLane]),
			.lane_sum_s1 (lane_sum_s1[g])
		);
	end

	lfpd_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (pipe.en2),
		.lane_sum_s1 (lane_sum_s1),
		.cfg         (cfg_q),
		.err_s2      (err_s2),
		.chg_s2      (chg_s2),
		.full_s2     (full_s2)
	);

	lfpd_drive u_drive (
		.clk             (clk),
		.pipe            (pipe),
		.cfg             (cfg_q),
		.err_s2          (err_s2),
		.chg_s2          (chg_s2),
		.full_s2         (full_s2),
		.servo_duty_s4   (steer.servo_duty),
		.steer_offset_s4 (steer.steer_offset),
		.full_gain_s4    (steer.full_gain)
	);

	assign steer.valid = v4_q;

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the PD steering block
// Drives row-center frames and register writes over valid/ready channels,
// computes each expected steering result in a local copy of the control law
// and compares every result transaction field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CycleLimit = 200000;
	localparam int DrainWait  = 8;
	localparam int LongHold   = 60;
	localparam int SweepItems = 190;
	localparam int SweepCount = 9;
	localparam int MaxReports = 10;
	localparam logic [lfpd_pkg::CfgIdxW-1:0] RegNone = 3'd7;

	typedef logic [lfpd_pkg::RowCount*lfpd_pkg::RowW-1:0] frame_t;

	typedef struct packed {
		logic [lfpd_pkg::DutyW-1:0]       servo_duty;
		logic signed [lfpd_pkg::OffW-1:0] steer_offset;
		logic                             full_gain;
	} steer_t;

	logic clk;
	logic arst_n;

	lfpd_rows_if  rows_ch ();
	lfpd_steer_if steer_ch ();
	lfpd_cfg_if   cfg_ch ();

	line_follow_pd_steering DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rows   (rows_ch),
		.steer  (steer_ch),
		.cfg    (cfg_ch)
	);

	// Local copy of the registers and the stored error
	lfpd_pkg::cfg_t shadow_regs;
	int             last_error;
	frame_t         last_frame;

	steer_t steer_due[$];
	steer_t steer_want;
	int     mismatches;

	// Idling controls shared with the channel processes
	bit src_gaps;
	bit sink_stalls;
	int hold_left;
	int stall_left;

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Cycle limit
	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	// Compute the steering result of one frame and advance the stored error
	function automatic steer_t next_steering(input frame_t f);
		int     sum, avg, err, change, lim, off, duty, sh, i;
		longint drive, mag;
		logic   full;
		steer_t r;
		sum = 0;
		for (i = 0; i < lfpd_pkg::RowCount; i++)
			sum += int'(f[i*lfpd_pkg::RowW +: lfpd_pkg::RowW]);
		avg    = sum / lfpd_pkg::RowCount;
		err    = avg - int'(shadow_regs.setpoint);
		change = err - last_error;
		full   = (err > int'(shadow_regs.band)) || (err < -int'(shadow_regs.band));
		drive  = longint'(shadow_regs.kp_q8) * err - longint'(shadow_regs.kd_q8) * change;
		sh     = lfpd_pkg::QBits + (full ? 0 : int'(shadow_regs.reduce_shift));
		// divide by a power of two, truncating toward zero
		mag = (drive < 0) ? -drive : drive;
		mag = mag >> sh;
		off = int'((drive < 0) ? -mag : mag);
		lim = int'(shadow_regs.offset_limit);
		if (off > lim)
			off = lim;
		if (off < -lim)
			off = -lim;
		duty = int'(shadow_regs.center_duty) + off;
		if (duty < 0)
			duty = 0;
		if (duty > lfpd_pkg::DutyMax)
			duty = lfpd_pkg::DutyMax;
		last_error     = err;
		r.servo_duty   = duty[lfpd_pkg::DutyW-1:0];
		r.steer_offset = off[lfpd_pkg::OffW-1:0];
		r.full_gain    = full;
		return r;
	endfunction

	function automatic void log_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MaxReports)
			$display("%s", msg);
	endfunction

	function automatic frame_t flat_frame(input logic [lfpd_pkg::RowW-1:0] v);
		return {lfpd_pkg::RowCount{v}};
	endfunction

	// Pick a field extreme now and then, otherwise any value
	function automatic int pick(input int hi);
		case ($urandom_range(0, 5))
			0: return 0;
			1: return hi;
			default: return int'($urandom_range(0, hi));
		endcase
	endfunction

	function automatic lfpd_pkg::cfg_t draw_settings();
		lfpd_pkg::cfg_t s;
		s.setpoint     = 8'(pick(255));
		s.kp_q8        = 12'(pick(4095));
		s.kd_q8        = 12'(pick(4095));
		// keep the band mostly narrow so both gain paths are hit
		s.band         = ($urandom_range(0, 3) == 0) ? 8'(pick(255))
		                                             : 8'($urandom_range(0, 60));
		s.reduce_shift = 3'(pick(7));
		s.offset_limit = 10'(pick(1023));
		s.center_duty  = 12'(pick(4095));
		return s;
	endfunction

	task automatic present_rows(input frame_t f);
		rows_ch.row_center_0  <= f[0*lfpd_pkg::RowW +: lfpd_pkg::RowW];
		rows_ch.row_center_1  <= f[1*lfpd_pkg::RowW +: lfpd_pkg::RowW];
		rows_ch.row_center_2  <= f[2*lfpd_pkg::RowW +: lfpd_pkg::RowW];
		rows_ch.row_center_3  <= f[3*lfpd_pkg::RowW +: lfpd_pkg::RowW];
		rows_ch.row_center_4  <= f[4*lfpd_pkg::RowW +: lfpd_pkg::RowW];
		rows_ch.row_center_5  <= f[5*lfpd_pkg::RowW +: lfpd_pkg::RowW];
		rows_ch.row_center_6  <= f[6*lfpd_pkg::RowW +: lfpd_pkg::RowW];
		rows_ch.row_center_7  <= f[7*lfpd_pkg::RowW +: lfpd_pkg::RowW];
		rows_ch.row_center_8  <= f[8*lfpd_pkg::RowW +: lfpd_pkg::RowW];
		rows_ch.row_center_9  <= f[9*lfpd_pkg::RowW +: lfpd_pkg::RowW];
		rows_ch.row_center_10 <= f[10*lfpd_pkg::RowW +: lfpd_pkg::RowW];
		rows_ch.row_center_11 <= f[11*lfpd_pkg::RowW +: lfpd_pkg::RowW];
	endtask

	// Offer one frame, hold it until taken, then queue its result
	task automatic send_frame(input frame_t f);
		if (src_gaps && $urandom_range(0, 3) == 0) begin
			rows_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		present_rows(f);
		rows_ch.valid <= 1'b1;
		do
			@(posedge clk);
		while (!rows_ch.ready);
		steer_due.push_back(next_steering(f));
	endtask

	// Stop offering frames and wait for every outstanding result
	task automatic drain();
		rows_ch.valid <= 1'b0;
		while (steer_due.size() != 0)
			@(posedge clk);
	endtask

	// One register transaction; the caller drops valid after its last write
	task automatic write_reg(input logic [lfpd_pkg::CfgIdxW-1:0] idx,
		input logic [lfpd_pkg::CfgDataW-1:0] d);
		cfg_ch.index <= idx;
		cfg_ch.data  <= d;
		cfg_ch.valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (idx)
			lfpd_pkg::REG_SETPOINT:     shadow_regs.setpoint     = d[7:0];
			lfpd_pkg::REG_KP_Q8:        shadow_regs.kp_q8        = d;
			lfpd_pkg::REG_KD_Q8:        shadow_regs.kd_q8        = d;
			lfpd_pkg::REG_BAND:         shadow_regs.band         = d[7:0];
			lfpd_pkg::REG_REDUCE_SHIFT: shadow_regs.reduce_shift = d[2:0];
			lfpd_pkg::REG_OFFSET_LIMIT: shadow_regs.offset_limit = d[lfpd_pkg::LimitW-1:0];
			lfpd_pkg::REG_CENTER_DUTY:  shadow_regs.center_duty  = d;
			default: ;
		endcase
	endtask

	// Write all registers; junk in the unused upper data bits must be dropped
	task automatic load_settings(input lfpd_pkg::cfg_t s);
		drain();
		write_reg(lfpd_pkg::REG_SETPOINT,     {4'($urandom), s.setpoint});
		write_reg(lfpd_pkg::REG_KP_Q8,        s.kp_q8);
		write_reg(lfpd_pkg::REG_KD_Q8,        s.kd_q8);
		write_reg(lfpd_pkg::REG_BAND,         {4'($urandom), s.band});
		write_reg(lfpd_pkg::REG_REDUCE_SHIFT, {9'($urandom), s.reduce_shift});
		write_reg(lfpd_pkg::REG_OFFSET_LIMIT, {2'($urandom), s.offset_limit});
		write_reg(lfpd_pkg::REG_CENTER_DUTY,  s.center_duty);
		cfg_ch.valid <= 1'b0;
	endtask

	// Random frame: mostly rows spread over the setpoint band and a margin
	// past both edges, some repeats for zero change, some pure noise
	task automatic draw_frame(output frame_t f);
		int base, row, i, kind;
		kind = int'($urandom_range(0, 9));
		if (kind == 0) begin
			f = {$urandom, $urandom, $urandom};
		end else if (kind == 1) begin
			f = last_frame;
		end else begin
			base = int'(shadow_regs.setpoint) - int'(shadow_regs.band) - 20
			     + int'($urandom_range(0, 2 * shadow_regs.band + 40));
			for (i = 0; i < lfpd_pkg::RowCount; i++) begin
				row = base + int'($urandom_range(0, 12)) - 6;
				if (row < 0)
					row = 0;
				if (row > 255)
					row = 255;
				f[i*lfpd_pkg::RowW +: lfpd_pkg::RowW] = 8'(row);
			end
		end
		last_frame = f;
	endtask

	// Result receiver: random stall bursts plus an optional long hold-off
	initial begin
		steer_ch.ready = 1'b0;
		stall_left     = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				steer_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				steer_ch.ready <= 1'b0;
			end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
				stall_left = int'($urandom_range(0, 7));
				steer_ch.ready <= 1'b0;
			end else begin
				steer_ch.ready <= 1'b1;
			end
		end
	end

	// Check each result transaction against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && steer_ch.valid && steer_ch.ready) begin
			if (steer_due.size() == 0) begin
				log_mismatch($sformatf("unexpected result: duty %0d offset %0d full %0b",
					steer_ch.servo_duty, steer_ch.steer_offset, steer_ch.full_gain));
			end else begin
				steer_want = steer_due.pop_front();
				if (steer_ch.servo_duty !== steer_want.servo_duty)
					log_mismatch($sformatf("servo_duty: expected %0d, got %0d",
						steer_want.servo_duty, steer_ch.servo_duty));
				if (steer_ch.steer_offset !== steer_want.steer_offset)
					log_mismatch($sformatf("steer_offset: expected %0d, got %0d",
						steer_want.steer_offset, steer_ch.steer_offset));
				if (steer_ch.full_gain !== steer_want.full_gain)
					log_mismatch($sformatf("full_gain: expected %0b, got %0b",
						steer_want.full_gain, steer_ch.full_gain));
			end
		end
	end

	// Default registers: zero error and both band edges
	task automatic test_reset_defaults();
		send_frame(flat_frame(8'd92));
		send_frame(flat_frame(8'd122));
		send_frame(flat_frame(8'd123));
		send_frame(flat_frame(8'd62));
		send_frame(flat_frame(8'd61));
	endtask

	// Row values at both ends and alternating bit patterns
	task automatic test_row_extremes();
		send_frame(flat_frame(8'h00));
		send_frame(flat_frame(8'hFF));
		send_frame({lfpd_pkg::RowCount/2{8'h55, 8'hAA}});
		send_frame({lfpd_pkg::RowCount/2{8'hAA, 8'h55}});
	endtask

	// Error exactly at the band stays on the reduced drive, one past it gets full gain
	task automatic test_band_edges();
		lfpd_pkg::cfg_t s;
		s = lfpd_pkg::CfgReset;
		s.band         = 8'd10;
		s.reduce_shift = 3'd7;
		s.offset_limit = 10'd1023;
		load_settings(s);
		send_frame(flat_frame(8'd102));
		send_frame(flat_frame(8'd103));
		send_frame(flat_frame(8'd82));
		send_frame(flat_frame(8'd81));
	endtask

	// A zero limit pins the offset to zero
	task automatic test_zero_limit();
		lfpd_pkg::cfg_t s;
		s = lfpd_pkg::CfgReset;
		s.offset_limit = 10'd0;
		load_settings(s);
		send_frame(flat_frame(8'hFF));
		send_frame(flat_frame(8'h00));
		send_frame(flat_frame(8'd92));
	endtask

	// Drive the duty below zero, then to its largest reachable value
	task automatic test_duty_saturation();
		lfpd_pkg::cfg_t s;
		s.setpoint     = 8'd255;
		s.kp_q8        = 12'd4095;
		s.kd_q8        = 12'd0;
		s.band         = 8'd0;
		s.reduce_shift = 3'd0;
		s.offset_limit = 10'd1023;
		s.center_duty  = 12'd0;
		load_settings(s);
		send_frame(flat_frame(8'h00));
		s.setpoint    = 8'd0;
		s.center_duty = 12'd4095;
		load_settings(s);
		send_frame(flat_frame(8'hFF));
	endtask

	// A write to an index past the last register must change nothing
	task automatic test_unused_index();
		drain();
		write_reg(RegNone, 12'hFFF);
		cfg_ch.valid <= 1'b0;
		send_frame(flat_frame(8'd200));
		send_frame(flat_frame(8'd10));
	endtask

	// Random frames under a series of register settings, with idling,
	// one long receiver hold-off, and a final stretch at full rate
	task automatic test_random_sweep();
		lfpd_pkg::cfg_t s;
		frame_t         f;
		int             phase, n;
		for (phase = 0; phase < SweepCount; phase++) begin
			if (phase == 0) begin
				s = '{8'd255, 12'd4095, 12'd4095, 8'd255, 3'd7, 10'd1023, 12'd4095};
			end else if (phase == 1) begin
				s = '0;
			end else begin
				s = draw_settings();
			end
			load_settings(s);
			if (phase == SweepCount - 1) begin
				src_gaps    = 1'b0;
				sink_stalls = 1'b0;
			end
			for (n = 0; n < SweepItems; n++) begin
				if (phase == 4 && n == 20) begin
					src_gaps  = 1'b0;
					hold_left = LongHold;
				end
				if (phase == 4 && n == 120)
					src_gaps = 1'b1;
				draw_frame(f);
				send_frame(f);
			end
		end
	endtask

	// Main sequence
	initial begin
		arst_n       = 1'b0;
		rows_ch.valid = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data  = '0;
		present_rows('0);
		shadow_regs  = lfpd_pkg::CfgReset;
		last_error   = 0;
		last_frame   = flat_frame(8'd92);
		mismatches   = 0;
		hold_left    = 0;
		src_gaps     = 1'b1;
		sink_stalls  = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_row_extremes();
		test_band_edges();
		test_zero_limit();
		test_duty_saturation();
		test_unused_index();
		test_random_sweep();

		// Let the pipeline empty and catch any stray result
		drain();
		repeat (DrainWait) @(posedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### line_follow_pd_steering.f
rtl/lfpd_pkg.sv
rtl/lfpd_rows_if.sv
rtl/lfpd_steer_if.sv
rtl/lfpd_cfg_if.sv
rtl/lfpd_lane.sv
rtl/lfpd_merge.sv
rtl/lfpd_drive.sv
rtl/line_follow_pd_steering.sv
tb/testbench.sv
